### sv/mpfb_pkg.sv
// Package for the monochrome page frame buffer rectangle draw unit.
// Opcodes, paint modes, index widths, parameter defaults and the store request struct.
// No dependencies.
package mpfb_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;

  // wide enough for any store index plus overshoot at the largest panel
  localparam int IDX_W   = 14;
  localparam int COORD_W = 13;

  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] MODE_SET = 2'd0;
  localparam logic [1:0] MODE_CLR = 2'd1;
  localparam logic [1:0] MODE_INV = 2'd2;
  localparam logic [1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

endpackage

### sv/mpfb_store.sv
// Frame store: simple dual-port RAM, one write and one registered read per cycle.
// Depends on mpfb_pkg.
module mpfb_store import mpfb_pkg::*; #(
  parameter int DEPTH = PANEL_WIDTH_DEF * ((PANEL_HEIGHT_DEF + 7) / 8)
) (
  input  logic       clk,
  input  store_req_t req,
  output logic [7:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.raddr[AW-1:0]];
  end

endmodule

### sv/mono_page_framebuffer_rect_draw_unit.sv
// Top level of the monochrome page frame buffer rectangle draw unit.
// Sequencer for draw, fill and read ops around the frame store.
// Depends on mpfb_pkg and mpfb_store.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one op per transfer: draw
//    rectangle, fill store, or read one panel byte. Opcode 3 is dropped.
//  - Output channel (out_valid/out_ready) carries read_data, one transfer
//    per read op; draw and fill produce nothing.
//  - Config channel (cfg_valid/cfg_ready, data on orientation) is always
//    ready; write it only while the unit is idle.
//  - Draw: a setup state, then a read state and a write state per touched
//    store byte (read, modify, write back through the single store read port).
//  - Fill: one store byte per cycle over all STORE_SIZE entries.
//  - Read: straight via S_RD, S_RD2 and S_RES; transposed via index split,
//    base compute and eight store reads pipelined through the read port.
//  - Reset: clearing pass writes zero to all STORE_SIZE entries (1024 at
//    default size); inputs are not accepted until it ends.
//  - Result sits in an output register; a new op is taken while it waits,
//    and a read finishing behind a stalled result holds until it is taken.
module mono_page_framebuffer_rect_draw_unit import mpfb_pkg::*; #(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic signed [10:0] x_pos,
  input  logic signed [10:0] y_pos,
  input  logic [9:0]  rect_width,
  input  logic [9:0]  rect_height,
  input  logic [1:0]  paint_mode,
  input  logic [7:0]  fill_byte,
  input  logic [9:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  orientation
);

  localparam int PAGES      = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_SIZE = PANEL_WIDTH * PAGES;
  localparam int TPAGES     = (PANEL_WIDTH + 7) / 8;
  localparam int RECIP      = 65536 / TPAGES;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DSETUP = 4'd1;
  localparam logic [3:0] S_DRD    = 4'd2;
  localparam logic [3:0] S_DWR    = 4'd3;
  localparam logic [3:0] S_FILL   = 4'd4;
  localparam logic [3:0] S_RD     = 4'd5;
  localparam logic [3:0] S_RD2    = 4'd6;
  localparam logic [3:0] S_TDIV   = 4'd7;
  localparam logic [3:0] S_TDIV2  = 4'd8;
  localparam logic [3:0] S_TBASE  = 4'd9;
  localparam logic [3:0] S_TRD    = 4'd10;
  localparam logic [3:0] S_RES    = 4'd11;

  logic [3:0]  state;
  logic [1:0]  orient;
  logic signed [10:0] rx, ry;
  logic [9:0]  rw, rh, ridx;
  logic [1:0]  rmode;
  logic [7:0]  rfill;
  logic [8:0]  x0, x1, cx;
  logic [7:0]  pg, pg0, pg1;
  logic [2:0]  ylo, yhi;
  logic [IDX_W-1:0] rowbase, sweep, tbase;
  logic [23:0] kprod;
  logic [6:0]  kq, tk, tp;
  logic [3:0]  cnt;
  logic        rd_pend, rd_oob;
  logic [2:0]  rd_m;
  logic [7:0]  res;
  logic [7:0]  rdata;
  store_req_t  req;
  logic        res_load;

  logic [8:0]  lw, lh;
  logic signed [COORD_W-1:0] xs_end, ys_end, x0s, y0s, x1s, y1s;
  logic        empty;
  logic [7:0]  mask, lo_m, hi_m;
  logic [IDX_W-1:0] waddr_cur, taddr;
  logic [6:0]  g;
  logic [7:0]  trem;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign lw = orient[0] ? 9'(PANEL_HEIGHT) : 9'(PANEL_WIDTH);
  assign lh = orient[0] ? 9'(PANEL_WIDTH) : 9'(PANEL_HEIGHT);
  assign res_load = (state == S_RES) && !rd_pend && (!out_valid || out_ready);

  always_comb begin
    xs_end = COORD_W'(rx) + COORD_W'(signed'({1'b0, rw})) - COORD_W'(1);
    ys_end = COORD_W'(ry) + COORD_W'(signed'({1'b0, rh})) - COORD_W'(1);
    x0s = rx[10] ? '0 : COORD_W'(rx);
    y0s = ry[10] ? '0 : COORD_W'(ry);
    x1s = (xs_end > signed'(COORD_W'(lw)) - COORD_W'(1)) ?
          signed'(COORD_W'(lw)) - COORD_W'(1) : xs_end;
    y1s = (ys_end > signed'(COORD_W'(lh)) - COORD_W'(1)) ?
          signed'(COORD_W'(lh)) - COORD_W'(1) : ys_end;
    empty = (rw == '0) || (rh == '0) || (rmode == MODE_NOP) || (x0s > x1s) || (y0s > y1s);
  end

  always_comb begin
    lo_m = 8'hFF << ((pg == pg0) ? ylo : 3'd0);
    hi_m = 8'hFF >> (3'd7 - ((pg == pg1) ? yhi : 3'd7));
    mask = lo_m & hi_m;
    waddr_cur = rowbase + IDX_W'(cx);
    g = ridx[9:3];
    trem = 8'(g) - 8'(kq * 7'(TPAGES));
    taddr = tbase + IDX_W'(cnt);
  end

  always_comb begin
    req = '0;
    case (state)
      S_FILL: begin
        req.we    = 1'b1;
        req.waddr = sweep;
        req.wdata = rfill;
      end
      S_DRD: req.raddr = waddr_cur;
      S_DWR: begin
        req.we    = 1'b1;
        req.waddr = waddr_cur;
        case (rmode)
          MODE_SET: req.wdata = rdata | mask;
          MODE_CLR: req.wdata = rdata & ~mask;
          MODE_INV: req.wdata = rdata ^ mask;
          default:  req.wdata = rdata;
        endcase
      end
      S_RD:  req.raddr = IDX_W'(ridx);
      S_TRD: req.raddr = taddr;
      default: req = '0;
    endcase
  end

  mpfb_store #(.DEPTH(STORE_SIZE)) u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      sweep     <= '0;
      rfill     <= '0;
      orient    <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        orient <= orientation;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= (state == S_TRD);
      if (rd_pend) begin
        res[rd_m] <= rd_oob ? 1'b0 : rdata[ridx[2:0]];
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rx <= x_pos; ry <= y_pos; rw <= rect_width; rh <= rect_height;
            rmode <= paint_mode; rfill <= fill_byte; ridx <= read_index;
            sweep <= '0;
            case (opcode)
              OP_DRAW: state <= S_DSETUP;
              OP_FILL: state <= S_FILL;
              OP_READ: begin
                if (32'(read_index) >= STORE_SIZE) begin
                  res   <= '0;
                  state <= S_RES;
                end else if (orient[0]) begin
                  state <= S_TDIV;
                end else begin
                  state <= S_RD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DSETUP: begin
          if (empty) begin
            state <= S_IDLE;
          end else begin
            x0  <= x0s[8:0];
            x1  <= x1s[8:0];
            cx  <= x0s[8:0];
            pg  <= y0s[10:3];
            pg0 <= y0s[10:3];
            pg1 <= y1s[10:3];
            ylo <= y0s[2:0];
            yhi <= y1s[2:0];
            rowbase <= IDX_W'(y0s[10:3]) * IDX_W'(lw);
            state <= S_DRD;
          end
        end
        S_DRD: state <= S_DWR;
        S_DWR: begin
          if (cx == x1) begin
            if (pg == pg1) begin
              state <= S_IDLE;
            end else begin
              pg      <= pg + 8'd1;
              rowbase <= rowbase + IDX_W'(lw);
              cx      <= x0;
              state   <= S_DRD;
            end
          end else begin
            cx    <= cx + 9'd1;
            state <= S_DRD;
          end
        end
        S_FILL: begin
          sweep <= sweep + IDX_W'(1);
          if (32'(sweep) == STORE_SIZE - 1) begin
            state <= S_IDLE;
          end
        end
        S_RD:  state <= S_RD2;
        S_RD2: begin
          res   <= rdata;
          state <= S_RES;
        end
        S_TDIV: begin
          kprod <= 24'(g) * 24'(RECIP);
          state <= S_TDIV2;
        end
        S_TDIV2: begin
          if (trem >= 8'(TPAGES)) begin
            tk <= kq + 7'd1;
            tp <= 7'(trem - 8'(TPAGES));
          end else begin
            tk <= kq;
            tp <= 7'(trem);
          end
          state <= S_TBASE;
        end
        S_TBASE: begin
          tbase <= IDX_W'({tk, 3'b000}) + IDX_W'(tp) * IDX_W'(PANEL_HEIGHT);
          res   <= '0;
          cnt   <= '0;
          state <= S_TRD;
        end
        S_TRD: begin
          rd_m    <= cnt[2:0];
          rd_oob  <= (32'(taddr) >= STORE_SIZE);
          cnt     <= cnt + 4'd1;
          if (cnt == 4'd7) begin
            state <= S_RES;
          end
        end
        S_RES: begin
          if (res_load) begin
            read_data <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign kq = kprod[22:16];

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !req.we)
    else $error("store written while idle");
  assert property (@(posedge clk) disable iff (rst) req.we |-> (32'(req.waddr) < STORE_SIZE))
    else $error("store write out of range");
  assert property (@(posedge clk) disable iff (rst) (state == S_DRD) |=> (state == S_DWR))
    else $error("read-modify-write broken");

endmodule
